// File: sv/hsmd_pkg.sv
// Shared constants, types and codes of the hybrid shift message decryptor.
`default_nettype none

package hsmd_pkg;

  // Key and field widths.
  localparam int KEY_W      = 16;
  localparam int PROD_W     = 2 * KEY_W;
  localparam int CHAR_W     = 8;
  localparam int BIT_IDX_W  = $clog2(KEY_W);
  localparam int RED_CNT_W  = $clog2(PROD_W);
  localparam int IN_DATA_W  = ((KEY_W + CHAR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CHAR_W + KEY_W + 7) / 8) * 8;

  // Printable character window.
  localparam int CHAR_RANGE = 95;
  localparam int KR_W       = $clog2(CHAR_RANGE);
  localparam logic [CHAR_W-1:0] PRINT_LO = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] PRINT_HI = CHAR_W'(32 + CHAR_RANGE - 1);

  // Reciprocal of the window size. For any shift below 2^KEY_W the quotient by
  // CHAR_RANGE is (shift * K_RECIP) >> K_RECIP_SH, since the rounding error of the
  // reciprocal times the shift stays below 2^K_RECIP_SH.
  localparam int K_RECIP_SH = KEY_W + 7;
  localparam int K_RECIP_W  = KEY_W + 1;
  localparam int KPROD_W    = KEY_W + K_RECIP_W;
  localparam int KQ_W       = KPROD_W - K_RECIP_SH;
  localparam logic [K_RECIP_W-1:0] K_RECIP =
    K_RECIP_W'(((longint'(1) << K_RECIP_SH) + longint'(CHAR_RANGE - 1)) /
               longint'(CHAR_RANGE));

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MOD  = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [KEY_W-1:0] PRIV_EXP_RST = KEY_W'(29);
  localparam logic [KEY_W-1:0] KEY_MOD_RST  = KEY_W'(95);

  // Operand source of the modular reduction unit.
  typedef enum logic [1:0] {
    RED_ENC   = 2'd0,
    RED_PROD  = 2'd1
  } red_src_e;

  // Controller states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_BASE_START = 11'b000_0000_0010,
    ST_BASE_WAIT  = 11'b000_0000_0100,
    ST_BIT_CHK    = 11'b000_0000_1000,
    ST_ACC_START  = 11'b000_0001_0000,
    ST_ACC_WAIT   = 11'b000_0010_0000,
    ST_SQ_START   = 11'b000_0100_0000,
    ST_SQ_WAIT    = 11'b000_1000_0000,
    ST_K_START    = 11'b001_0000_0000,
    ST_K_WAIT     = 11'b010_0000_0000,
    ST_EMIT       = 11'b100_0000_0000
  } hsmd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     set_err_shift;
    logic     set_one_shift;
    logic     red_start;
    red_src_e red_src;
    logic     base_load;
    logic     mul_acc;
    logic     mul_sq;
    logic     acc_load;
    logic     sq_load;
    logic     bit_inc;
    logic     shift_load;
    logic     k_load;
    logic     load_out;
    logic     out_from_input;
  } hsmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_bit;
    logic last_bit;
    logic red_done;
  } hsmd_status_t;

endpackage

`default_nettype wire

// File: sv/hsmd_modred.sv
// Bit-serial restoring reduction of a double-width value modulo a key-width divisor.
`default_nettype none

module hsmd_modred
  import hsmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] x_i,
  input  logic [KEY_W-1:0]  d_i,
  output logic              done_o,
  output logic [KEY_W-1:0]  rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    x_q, x_d;
  logic [KEY_W-1:0]     rem_q, rem_d;
  logic [KEY_W-1:0]     d_q, d_d;
  logic [KEY_W:0]       trial;
  logic [KEY_W:0]       trial_sub;

  // One quotient bit per cycle; the partial remainder stays below the divisor.
  always_comb begin
    trial     = {rem_q, x_q[PROD_W-1]};
    trial_sub = trial - {1'b0, d_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    x_d       = x_q;
    rem_d     = rem_q;
    d_d       = d_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = RED_CNT_W'(PROD_W - 1);
      x_d    = x_i;
      rem_d  = '0;
      d_d    = d_i;
    end else if (busy_q) begin
      x_d   = x_q << 1;
      rem_d = (trial >= {1'b0, d_q}) ? trial_sub[KEY_W-1:0] : trial[KEY_W-1:0];
      cnt_d = cnt_q - RED_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
    d_q   <= d_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("reduction restarted while busy");

  a_done_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == '0) |=> done_q)
    else $error("reduction did not finish after its last step");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < d_q))
    else $error("remainder not below divisor");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still busy");
`endif

endmodule

`default_nettype wire

// File: sv/hsmd_datapath.sv
// Datapath: key registers, modular exponentiation operands, shift store and character unshift.
`default_nettype none

module hsmd_datapath
  import hsmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsmd_cmd_t             cmd_i,
  output hsmd_status_t          status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KEY_W-1:0]      cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  in_last_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_err_o,
  output logic                  out_last_o
);

  logic [KEY_W-1:0]     exp_q, mod_q;
  logic [KEY_W-1:0]     shift_q;
  logic [KR_W-1:0]      k_q;
  logic [KEY_W-1:0]     enc_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  logic [KEY_W-1:0]     sq_q, acc_q;
  logic [PROD_W-1:0]    prod_q;
  logic [KPROD_W-1:0]   kprod_q;
  logic [BIT_IDX_W-1:0] bit_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic [KEY_W-1:0]     out_shift_q;
  logic                 out_err_q, out_last_q;

  logic [KEY_W-1:0]     in_enc;
  logic [CHAR_W-1:0]    in_char;
  logic [KEY_W-1:0]     mul_a;
  logic [PROD_W-1:0]    red_x;
  logic [KEY_W-1:0]     red_d;
  logic                 red_done;
  logic [KEY_W-1:0]     red_rem;
  logic [KQ_W-1:0]      k_quot;
  logic [KEY_W-1:0]     k_rem;
  logic [CHAR_W-1:0]    char_src;
  logic                 printable;
  logic [KR_W-1:0]      off;
  logic [KR_W-1:0]      diff;
  logic [CHAR_W-1:0]    plain;

  assign in_enc  = in_data_i[KEY_W-1:0];
  assign in_char = in_data_i[KEY_W +: CHAR_W];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= PRIV_EXP_RST;
      mod_q <= KEY_MOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRIV_EXP: exp_q <= cfg_wdata_i;
        CFG_KEY_MOD:  mod_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Residue of the stored shift in the printable window: the registered reciprocal
  // product gives the quotient, and one multiply-subtract leaves the remainder.
  assign k_quot = kprod_q[KPROD_W-1:K_RECIP_SH];
  assign k_rem  = shift_q - (KEY_W'(k_quot) * KEY_W'(CHAR_RANGE));

  // Shift of the current message and its residue in the printable window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.set_err_shift) begin
        shift_q <= '0;
        k_q     <= '0;
      end else if (cmd_i.set_one_shift) begin
        shift_q <= KEY_W'(1);
        k_q     <= KR_W'(1);
      end else if (cmd_i.shift_load) begin
        shift_q <= acc_q;
      end
      if (cmd_i.k_load) begin
        k_q <= k_rem[KR_W-1:0];
      end
    end
  end

  // Exponentiation operands, single shared multiplier.
  assign mul_a = cmd_i.mul_acc ? acc_q : sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      enc_q  <= in_enc;
      char_q <= in_char;
      last_q <= in_last_i;
    end
    if (cmd_i.mul_acc || cmd_i.mul_sq) begin
      prod_q <= mul_a * sq_q;
    end
    kprod_q <= KPROD_W'(shift_q) * KPROD_W'(K_RECIP);
    if (cmd_i.base_load) begin
      sq_q  <= red_rem;
      acc_q <= KEY_W'(mod_q != KEY_W'(1));
      bit_q <= '0;
    end else begin
      if (cmd_i.sq_load) begin
        sq_q <= red_rem;
      end
      if (cmd_i.acc_load) begin
        acc_q <= red_rem;
      end
      if (cmd_i.bit_inc) begin
        bit_q <= bit_q + BIT_IDX_W'(1);
      end
    end
  end

  always_comb begin
    case (cmd_i.red_src)
      RED_ENC: begin
        red_x = PROD_W'(enc_q);
        red_d = mod_q;
      end
      RED_PROD: begin
        red_x = prod_q;
        red_d = mod_q;
      end
      default: begin
        red_x = prod_q;
        red_d = mod_q;
      end
    endcase
  end

  hsmd_modred u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.red_start),
    .x_i     (red_x),
    .d_i     (red_d),
    .done_o  (red_done),
    .rem_o   (red_rem)
  );

  // Unshift within the printable window; the wrap sum may pass 2^KR_W, but the true
  // result lies below CHAR_RANGE, so the modular arithmetic still gives it exactly.
  always_comb begin
    char_src  = cmd_i.out_from_input ? in_char : char_q;
    printable = (char_src >= PRINT_LO) && (char_src <= PRINT_HI);
    off       = KR_W'(char_src - PRINT_LO);
    if (off >= k_q) begin
      diff = off - k_q;
    end else begin
      diff = off + KR_W'(CHAR_RANGE) - k_q;
    end
    plain = printable ? (CHAR_W'(diff) + PRINT_LO) : char_src;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_char_q  <= plain;
      out_shift_q <= shift_q;
      out_err_q   <= (mod_q == '0);
      out_last_q  <= cmd_i.out_from_input ? in_last_i : last_q;
    end
  end

  assign out_data_o = OUT_DATA_W'({out_shift_q, out_char_q});
  assign out_err_o  = out_err_q;
  assign out_last_o = out_last_q;

  assign status_o.mod_zero = (mod_q == '0);
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_bit  = exp_q[bit_q];
  assign status_o.last_bit = (bit_q == BIT_IDX_W'(KEY_W - 1));
  assign status_o.red_done = red_done;

endmodule

`default_nettype wire

// File: sv/hsmd_ctrl.sv
// Controller: handshakes and the square-and-multiply sequence.
`default_nettype none

module hsmd_ctrl
  import hsmd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_start_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  hsmd_status_t status_i,
  output hsmd_cmd_t    cmd_o
);

  hsmd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        space;
  hsmd_cmd_t   cmd;

  assign space      = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && space;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_start_i) begin
            cmd.capture = 1'b1;
            if (status_i.mod_zero) begin
              cmd.set_err_shift = 1'b1;
              state_d = ST_EMIT;
            end else if (status_i.exp_zero) begin
              cmd.set_one_shift = 1'b1;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_BASE_START;
            end
          end else begin
            cmd.load_out       = 1'b1;
            cmd.out_from_input = 1'b1;
          end
        end
      end
      ST_BASE_START: begin
        cmd.red_start = 1'b1;
        cmd.red_src   = RED_ENC;
        state_d       = ST_BASE_WAIT;
      end
      ST_BASE_WAIT: begin
        if (status_i.red_done) begin
          cmd.base_load = 1'b1;
          state_d       = ST_BIT_CHK;
        end
      end
      ST_BIT_CHK: begin
        if (status_i.exp_bit) begin
          cmd.mul_acc = 1'b1;
          state_d     = ST_ACC_START;
        end else begin
          cmd.mul_sq = 1'b1;
          state_d    = ST_SQ_START;
        end
      end
      ST_ACC_START: begin
        cmd.red_start = 1'b1;
        cmd.red_src   = RED_PROD;
        state_d       = ST_ACC_WAIT;
      end
      ST_ACC_WAIT: begin
        if (status_i.red_done) begin
          cmd.acc_load = 1'b1;
          cmd.mul_sq   = 1'b1;
          state_d      = ST_SQ_START;
        end
      end
      ST_SQ_START: begin
        cmd.red_start = 1'b1;
        cmd.red_src   = RED_PROD;
        state_d       = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (status_i.red_done) begin
          cmd.sq_load = 1'b1;
          if (status_i.last_bit) begin
            cmd.shift_load = 1'b1;
            state_d        = ST_K_START;
          end else begin
            cmd.bit_inc = 1'b1;
            state_d     = ST_BIT_CHK;
          end
        end
      end
      ST_K_START: begin
        // The reciprocal product of the new shift is registered in this cycle.
        state_d = ST_K_WAIT;
      end
      ST_K_WAIT: begin
        cmd.k_load = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (space) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

// File: sv/hybrid_shift_message_decrypt_unit.sv
// Top level of the hybrid shift message decryptor.
//
//   Channel   Direction  Carries
//   s_axis    in         tdata: encrypted_shift, cipher_char; tuser: start_of_message;
//                        tlast: last_in
//   m_axis    out        tdata: plain_char, shift_value; tuser: modulus_error;
//                        tlast: last_out
//   cfg       in         write of private_exponent (index 0) or key_modulus (index 1)
//
// A beat without start_of_message has its result registered at the accepting edge,
// so such beats stream at one per cycle while the output side drains.
// A start beat runs square-and-multiply on the one shared multiplier and the
// bit-serial reduction unit; the shift residue in the printable window then comes
// from a reciprocal multiplication. With a zero modulus or a zero exponent a start
// beat skips the exponentiation. Reset (rst_ni, asynchronous, active low) loads
// exponent 29, modulus 95 and a stored shift of zero. A stalled output holds its
// beat and blocks new input beats once full.
`default_nettype none

module hybrid_shift_message_decrypt_unit
  import hsmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] encrypted_shift, [23:16] cipher_char
  input  logic                  s_axis_tuser,   // [0] start_of_message
  input  logic                  s_axis_tlast,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] plain_char, [23:8] shift_value
  output logic                  m_axis_tuser,   // [0] modulus_error
  output logic                  m_axis_tlast,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KEY_W-1:0]      cfg_wdata_i
);

  hsmd_cmd_t    cmd;
  hsmd_status_t status;

  // The controller sequences the exponentiation and owns both handshakes.
  hsmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_start_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the key, the stored shift and the output register.
  hsmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: verif/tb_hybrid_shift_message_decrypt_unit.sv
// Self-checking testbench for the hybrid shift message decryptor with randomized traffic.
module tb_hybrid_shift_message_decrypt_unit;
  import hsmd_pkg::*;

  // One input beat: a message character, with the encrypted key on a start beat.
  typedef struct {
    bit                start;
    logic [KEY_W-1:0]  enc;
    logic [CHAR_W-1:0] ch;
    bit                last;
  } char_beat_t;

  // One output beat: the recovered character and its side information.
  typedef struct {
    logic [CHAR_W-1:0] plain;
    logic [KEY_W-1:0]  shift;
    bit                err;
    bit                last;
  } plain_beat_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Cycles allowed for outstanding beats to come out before the run gives up on them.
  localparam int DRAIN_LIMIT   = 20000;
  // Quiet cycles after the last expected beat, before a key write or the verdict.
  localparam int SETTLE_CYCLES = 16;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 400;
  // Random beats per key setting.
  localparam int BEATS_PER_PHASE = 215;
  localparam int NUM_PHASES      = 9;

  // Mirrors the key registers and the stored shift, and keeps the characters still
  // owed by the block in arrival order.
  class decrypt_scoreboard;
    logic [KEY_W-1:0] exponent;
    logic [KEY_W-1:0] modulus;
    logic [KEY_W-1:0] shift;
    plain_beat_t      expected_plain[$];
    int unsigned      failures;

    function new();
      exponent = PRIV_EXP_RST;
      modulus  = KEY_MOD_RST;
      shift    = '0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      if (idx == CFG_PRIV_EXP) exponent = value;
      else if (idx == CFG_KEY_MOD) modulus = value;
    endfunction

    // Square-and-multiply over the exponent bits; a zero exponent yields one.
    function logic [KEY_W-1:0] power_mod(logic [KEY_W-1:0] base, logic [KEY_W-1:0] expo,
                                         logic [KEY_W-1:0] m);
      longint unsigned acc;
      longint unsigned sq;
      int              b;
      if (expo == 0) return KEY_W'(1);
      sq  = base % m;
      acc = 1 % m;
      for (b = 0; b < KEY_W; b++) begin
        if (expo[b]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[KEY_W-1:0];
    endfunction

    // Rotates a printable character back by the shift inside the printable window.
    function logic [CHAR_W-1:0] shift_back(logic [CHAR_W-1:0] ch, logic [KEY_W-1:0] s);
      int unsigned k;
      int unsigned off;
      if (ch < PRINT_LO || ch > PRINT_HI) return ch;
      k   = s % CHAR_RANGE;
      off = ch - PRINT_LO;
      off = (off + CHAR_RANGE - k) % CHAR_RANGE;
      return CHAR_W'(off + PRINT_LO);
    endfunction

    function void note_input(char_beat_t b);
      plain_beat_t e;
      if (b.start) shift = (modulus == 0) ? '0 : power_mod(b.enc, exponent, modulus);
      e.plain = shift_back(b.ch, shift);
      e.shift = shift;
      e.err   = (modulus == 0);
      e.last  = b.last;
      expected_plain.push_back(e);
    endfunction

    function void check_result(plain_beat_t got);
      plain_beat_t e;
      if (expected_plain.size() == 0) begin
        $error("unexpected output beat: plain_char %0d, shift_value %0d", got.plain, got.shift);
        failures++;
        return;
      end
      e = expected_plain.pop_front();
      if (got.plain !== e.plain) begin
        $error("plain_char: expected %0d, actual %0d", e.plain, got.plain);
        failures++;
      end
      if (got.shift !== e.shift) begin
        $error("shift_value: expected %0d, actual %0d", e.shift, got.shift);
        failures++;
      end
      if (got.err !== e.err) begin
        $error("modulus_error: expected %0d, actual %0d", e.err, got.err);
        failures++;
      end
      if (got.last !== e.last) begin
        $error("last_out: expected %0d, actual %0d", e.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] encrypted_shift, [23:16] cipher_char
  logic                  s_axis_tuser  = 1'b0; // [0] start_of_message
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [7:0] plain_char, [23:8] shift_value
  logic                  m_axis_tuser;         // [0] modulus_error
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_PRIV_EXP;
  logic [KEY_W-1:0]      cfg_wdata_i   = '0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  // High while the long receiver hold-off is in progress.
  bit          hold_active = 1'b0;
  event        rx_hold_start;

  decrypt_scoreboard sb = new();

  hybrid_shift_message_decrypt_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Output side. A beat is taken at an edge where tvalid and tready were both high;
  // tready for the next cycle is then redrawn, unless the long hold-off is running.
  always @(posedge clk_i) begin
    plain_beat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.plain = m_axis_tdata[CHAR_W-1:0];
      got.shift = m_axis_tdata[CHAR_W +: KEY_W];
      got.err   = m_axis_tuser;
      got.last  = m_axis_tlast;
      sb.check_result(got);
    end
    if (hold_active) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // The hold-off counts its own cycles. Its flag changes on the falling edge so that
  // the output process always sees a settled value.
  initial begin
    forever begin
      @(rx_hold_start);
      @(negedge clk_i);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_active = 1'b0;
    end
  end

  function automatic char_beat_t mk_beat(bit start, logic [KEY_W-1:0] enc,
                                         logic [CHAR_W-1:0] ch, bit last);
    char_beat_t b;
    b.start = start;
    b.enc   = enc;
    b.ch    = ch;
    b.last  = last;
    return b;
  endfunction

  // Encrypted keys lean toward the corners: zero, one, all ones and modulus minus one.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(15))
      0:       return '0;
      1:       return KEY_W'(1);
      2:       return '1;
      3:       return sb.modulus - KEY_W'(1);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Mostly printable text, some window edges, and the odd arbitrary byte.
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 14) return CHAR_W'($urandom_range(PRINT_HI, PRINT_LO));
    if (r < 17) begin
      case ($urandom_range(3))
        0:       return PRINT_LO - CHAR_W'(1);
        1:       return PRINT_LO;
        2:       return PRINT_HI;
        default: return PRINT_HI + CHAR_W'(1);
      endcase
    end
    return CHAR_W'($urandom_range(255));
  endfunction

  // Offers one beat after a random number of idle cycles and returns at the edge that
  // takes it. tvalid stays high on return, so back-to-back beats never see it dip.
  task automatic send_beat(char_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({b.ch, b.enc});
    s_axis_tuser  <= b.start;
    s_axis_tlast  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b);
  endtask

  // Writes both key registers back to back while the block is idle.
  task automatic write_keys(logic [KEY_W-1:0] expo, logic [KEY_W-1:0] modulus);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PRIV_EXP;
    cfg_wdata_i <= expo;
    @(posedge clk_i);
    sb.write_register(CFG_PRIV_EXP, expo);
    cfg_index_i <= CFG_KEY_MOD;
    cfg_wdata_i <= modulus;
    @(posedge clk_i);
    sb.write_register(CFG_KEY_MOD, modulus);
    cfg_we_i <= 1'b0;
  endtask

  // Stops offering beats and waits until every expected character has come out.
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_plain.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.expected_plain.size() != 0) begin
      $error("%0d expected output beats never arrived", sb.expected_plain.size());
      sb.failures++;
      sb.expected_plain.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random messages: a start beat carrying the key, then characters, last on the
  // final one. About one message in eight is noise with random start and last flags.
  task automatic run_messages(int count);
    int         sent;
    int         len;
    int         i;
    bit         noise;
    char_beat_t b;
    sent = 0;
    while (sent < count) begin
      noise = ($urandom_range(99) < 12);
      len   = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(12, 1);
      for (i = 0; i < len; i++) begin
        b.enc = pick_key();
        b.ch  = pick_char();
        if (noise) begin
          b.start = 1'($urandom_range(1));
          b.last  = 1'($urandom_range(1));
        end else begin
          b.start = (i == 0);
          b.last  = (i == len - 1);
        end
        send_beat(b);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int               p;
    idle_mode_e       mode;
    logic [KEY_W-1:0] key_exp[NUM_PHASES];
    logic [KEY_W-1:0] key_mod[NUM_PHASES];

    // Key settings per phase. The first phase runs on the reset keys; the others
    // cover the all-ones extremes, a zero exponent, a zero modulus (alone and with a
    // zero exponent), an exponent of one, a modulus of one and two random keys.
    key_exp = '{PRIV_EXP_RST, 16'hFFFF, 16'd0, 16'd29, 16'd0, 16'd1, 16'd0, 16'd0, 16'hFFFF};
    key_mod = '{KEY_MOD_RST, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd95, 16'd1};
    key_exp[6] = KEY_W'($urandom);
    key_mod[6] = KEY_W'($urandom);
    key_exp[7] = KEY_W'($urandom);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < NUM_PHASES; p++) begin
      // Idling rotates through none, sender only, receiver only and both.
      mode = idle_mode_e'(p % 4);
      idle_pct  = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 18 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 18 : 0;
      if (p != 0) begin
        drain();
        write_keys(key_exp[p], key_mod[p]);
      end
      if (p == 0) begin
        // Characters before any start beat use the reset shift of zero.
        send_beat(mk_beat(1'b0, 16'h1234, 8'd65, 1'b0));
        send_beat(mk_beat(1'b0, 16'h0000, 8'd0, 1'b0));
        send_beat(mk_beat(1'b0, 16'hFFFF, 8'd255, 1'b0));
        // Key extremes; the start character is decrypted with its own new shift.
        send_beat(mk_beat(1'b1, 16'h0000, PRINT_LO, 1'b0));
        send_beat(mk_beat(1'b1, 16'hFFFF, PRINT_HI, 1'b1));
        // A full message touching both window edges and the bytes just outside it.
        send_beat(mk_beat(1'b1, 16'd2, PRINT_LO, 1'b0));
        send_beat(mk_beat(1'b0, 16'd0, PRINT_HI, 1'b0));
        send_beat(mk_beat(1'b0, 16'd0, PRINT_LO - CHAR_W'(1), 1'b0));
        send_beat(mk_beat(1'b0, 16'd0, PRINT_HI + CHAR_W'(1), 1'b0));
        send_beat(mk_beat(1'b0, 16'hFFFF, 8'd255, 1'b1));
        // A one-character message: start and last on the same beat.
        send_beat(mk_beat(1'b1, 16'd94, 8'd80, 1'b1));
        send_beat(mk_beat(1'b1, 16'd1, 8'd33, 1'b0));
        send_beat(mk_beat(1'b0, 16'h5555, 8'h55, 1'b0));
        send_beat(mk_beat(1'b0, 16'hAAAA, 8'hAA, 1'b1));
      end
      // Start beats are short with a zero modulus and zero exponent, so this phase is
      // the one where a long receiver hold-off actually backs the block up.
      if (p == 4) -> rx_hold_start;
      run_messages(BEATS_PER_PHASE);
    end

    drain();
    if (sb.failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legitimate run.
  initial begin
    #(12 * 3_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/hsmd_pkg.sv
sv/hsmd_modred.sv
sv/hsmd_datapath.sv
sv/hsmd_ctrl.sv
sv/hybrid_shift_message_decrypt_unit.sv
verif/tb_hybrid_shift_message_decrypt_unit.sv
